// ----- rtl/twelve_bit_minicomputer_core_defines.svh -----
// assertion macros for the twelve-bit minicomputer core checker
// no dependencies; included by files that carry assertions
`ifndef TWELVE_BIT_MINICOMPUTER_CORE_DEFINES_SVH
`define TWELVE_BIT_MINICOMPUTER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define TBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("core assertion failed");

// next-cycle implication, off during reset
`define TBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("core assertion failed");

`endif

// ----- rtl/pdp8_pkg.sv -----
// shared types, constants and address helper for the twelve-bit minicomputer core
// no dependencies
package pdp8_pkg;

  localparam int WORD_W       = 12;
  localparam int CMD_W        = 2;
  localparam int ADDR_SPACE   = 4096;
  localparam int MEMORY_WORDS = 4096;
  localparam int ADDR_W       = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
  localparam int MOD_STEPS    = $clog2((ADDR_SPACE + MEMORY_WORDS - 1) / MEMORY_WORDS);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [WORD_W-1:0] AUTOINC_BASE = 12'o0010;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP    = 2'd0,
    CMD_DEPOSIT = 2'd1,
    CMD_LOAD_PC = 2'd2,
    CMD_START   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_AND = 3'd0,
    OP_TAD = 3'd1,
    OP_ISZ = 3'd2,
    OP_DCA = 3'd3,
    OP_JMS = 3'd4,
    OP_JMP = 3'd5,
    OP_IOT = 3'd6,
    OP_OPR = 3'd7
  } opcode_e;

  // word address folded onto the memory, restoring compare-subtract steps
  function automatic logic [ADDR_W-1:0] mem_index(logic [WORD_W-1:0] a);
    logic [WORD_W:0] r;
    r = {1'b0, a};
    for (int i = MOD_STEPS - 1; i >= 0; i--) begin
      if (r >= (WORD_W + 1)'(MEMORY_WORDS << i)) begin
        r = r - (WORD_W + 1)'(MEMORY_WORDS << i);
      end
    end
    return r[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/twelve_bit_minicomputer_core.sv -----
// twelve-bit accumulator machine with internal main memory, one command per item
// from accept: deposit, pc load, start and halted step go straight to done; iot via fetch;
// operate via fetch and oper; direct memory reference via fetch and exec; indirect adds defer
// one item at a time: the next item is taken the cycle after the result is issued;
// done waits while the output is stalled; fetch, defer and execute share one port
// reset clears the registers and sets halted; memory content is not cleared
module twelve_bit_minicomputer_core
  import pdp8_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [WORD_W-1:0]       cfg_wdata_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // address [11:0], data [23:12]
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,
  // cmd [1:0]
  input  logic [CMD_W-1:0]        s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // program_counter_out [11:0], accumulator_out [23:12], link_out [24],
  // last_word [36:25], halted_out [37], unsupported [38], zero [39]
  output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DEFER,
    S_EXEC,
    S_OPER,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [WORD_W-1:0]   pc_q, ac_q, ma_q, md_q, ir_q, sr_q;
  logic                link_q, halted_q, unsup_q;
  logic                out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                fwd_q;
  logic [WORD_W-1:0]   fwd_data_q;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata, rd;

  logic                in_accept;
  cmd_e                in_cmd;
  logic [WORD_W-1:0]   in_addr, in_data;
  opcode_e             op_f, op_x;
  logic [WORD_W-1:0]   ea_f, ptr_inc, ptr_eff, rd_inc;
  logic                autoinc;
  logic [WORD_W:0]     tad_sum;

  logic [WORD_W-1:0]   opr_ac, opr_pc;
  logic                opr_link, opr_halt;

  pdp8_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MEMORY_WORDS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign in_addr       = s_axis_tdata[WORD_W-1:0];
  assign in_data       = s_axis_tdata[2*WORD_W-1:WORD_W];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // read data with bypass of a write to the same entry in the read cycle
  assign rd      = fwd_q ? fwd_data_q : ram_rdata;
  assign op_f    = opcode_e'(rd[11:9]);
  assign op_x    = opcode_e'(ir_q[11:9]);
  assign ea_f    = {(rd[7] ? pc_q[11:7] : 5'd0), rd[6:0]};
  assign autoinc = (ma_q[11:3] == AUTOINC_BASE[11:3]);
  assign ptr_inc = rd + 12'd1;
  assign ptr_eff = autoinc ? ptr_inc : rd;
  assign rd_inc  = rd + 12'd1;
  assign tad_sum = {1'b0, ac_q} + {1'b0, rd};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mem_index(ma_q);
    ram_wdata = ac_q;
    ram_raddr = mem_index(pc_q);
    case (state_q)
      S_IDLE: begin
        if (in_accept && in_cmd == CMD_DEPOSIT) begin
          ram_we    = 1'b1;
          ram_waddr = mem_index(in_addr);
          ram_wdata = in_data;
        end
      end
      S_FETCH: begin
        ram_raddr = mem_index(ea_f);
      end
      S_DEFER: begin
        ram_raddr = mem_index(ptr_eff);
        if (autoinc) begin
          ram_we    = 1'b1;
          ram_wdata = ptr_inc;
        end
      end
      S_EXEC: begin
        case (op_x)
          OP_ISZ: begin
            ram_we    = 1'b1;
            ram_wdata = rd_inc;
          end
          OP_DCA: begin
            ram_we    = 1'b1;
            ram_wdata = ac_q;
          end
          OP_JMS: begin
            ram_we    = 1'b1;
            ram_wdata = pc_q;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // operate instructions on the held instruction word
  always_comb begin
    logic [WORD_W-1:0] a;
    logic              l;
    logic [WORD_W:0]   s;
    logic              cond;
    logic              skip;
    a        = ac_q;
    l        = link_q;
    s        = '0;
    cond     = 1'b0;
    skip     = 1'b0;
    opr_pc   = pc_q;
    opr_halt = halted_q;
    if (!ir_q[8]) begin
      if (ir_q[7]) a = '0;
      if (ir_q[6]) l = 1'b0;
      if (ir_q[5]) a = ~a;
      if (ir_q[4]) l = ~l;
      if (ir_q[0]) begin
        s = {1'b0, a} + 13'd1;
        a = s[WORD_W-1:0];
        l = l ^ s[WORD_W];
      end
      if (ir_q[3]) begin
        {l, a} = {a[0], l, a[11:1]};
        if (ir_q[1]) {l, a} = {a[0], l, a[11:1]};
      end
      if (ir_q[2]) begin
        {l, a} = {a[11], a[10:0], l};
        if (ir_q[1]) {l, a} = {a[11], a[10:0], l};
      end
    end else if (!ir_q[0]) begin
      cond = (ir_q[6] && a[11]) || (ir_q[5] && (a == '0)) || (ir_q[4] && l);
      skip = ir_q[3] ? !cond : cond;
      if (skip) opr_pc = pc_q + 12'd1;
      if (ir_q[7]) a = '0;
      if (ir_q[2]) a = a | sr_q;
      if (ir_q[1]) opr_halt = 1'b1;
    end else begin
      if (ir_q[7]) a = '0;
    end
    opr_ac   = a;
    opr_link = l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      ac_q        <= '0;
      link_q      <= 1'b0;
      ma_q        <= '0;
      md_q        <= '0;
      ir_q        <= '0;
      sr_q        <= '0;
      halted_q    <= 1'b1;
      unsup_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      fwd_q       <= 1'b0;
      fwd_data_q  <= '0;
    end else begin
      fwd_q      <= ram_we && (ram_waddr == ram_raddr);
      fwd_data_q <= ram_wdata;
      if (cfg_we_i) sr_q <= cfg_wdata_i;
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            unsup_q <= 1'b0;
            state_q <= (in_cmd == CMD_STEP && !halted_q) ? S_FETCH : S_DONE;
            case (in_cmd)
              CMD_STEP: ;
              CMD_DEPOSIT: begin
                ma_q <= in_addr;
                md_q <= in_data;
              end
              CMD_LOAD_PC: begin
                pc_q <= in_addr;
              end
              CMD_START: begin
                ac_q     <= '0;
                link_q   <= 1'b0;
                md_q     <= '0;
                ma_q     <= pc_q;
                halted_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          md_q <= rd;
          ir_q <= rd;
          ma_q <= ea_f;
          pc_q <= pc_q + 12'd1;
          if (op_f == OP_IOT) begin
            unsup_q <= 1'b1;
            state_q <= S_DONE;
          end else if (op_f == OP_OPR) begin
            state_q <= S_OPER;
          end else if (rd[8]) begin
            state_q <= S_DEFER;
          end else begin
            state_q <= S_EXEC;
          end
        end
        S_DEFER: begin
          md_q    <= ptr_eff;
          ma_q    <= ptr_eff;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (op_x)
            OP_AND: begin
              md_q <= rd;
              ac_q <= ac_q & rd;
            end
            OP_TAD: begin
              md_q   <= rd;
              ac_q   <= tad_sum[WORD_W-1:0];
              link_q <= link_q ^ tad_sum[WORD_W];
            end
            OP_ISZ: begin
              md_q <= rd_inc;
              if (rd_inc == '0) pc_q <= pc_q + 12'd1;
            end
            OP_DCA: begin
              md_q <= ac_q;
              ac_q <= '0;
            end
            OP_JMS: begin
              md_q <= pc_q;
              pc_q <= ma_q + 12'd1;
            end
            OP_JMP: begin
              pc_q <= ma_q;
            end
            default: ;
          endcase
          state_q <= S_DONE;
        end
        S_OPER: begin
          ac_q     <= opr_ac;
          link_q   <= opr_link;
          pc_q     <= opr_pc;
          halted_q <= opr_halt;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_data_q  <= {1'b0, unsup_q, halted_q, md_q, link_q, ac_q, pc_q};
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/pdp8_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pdp8_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                  wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pdp8_checker.sv -----
// port-level assertions for the twelve-bit minicomputer core, bound to the top level
// depends on twelve_bit_minicomputer_core_defines.svh and pdp8_pkg
`include "twelve_bit_minicomputer_core_defines.svh"

module pdp8_checker
  import pdp8_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  logic m_stall;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  `TBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_stall, m_axis_tvalid)
  `TBM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_stall, $stable(m_axis_tdata))
  `TBM_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_acc, !s_axis_tready)
  `TBM_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, s_acc && !m_axis_tvalid, !m_axis_tvalid)
  `TBM_ASSERT_SAME(a_iot_runs, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[38], !m_axis_tdata[37])

endmodule

bind twelve_bit_minicomputer_core pdp8_checker u_pdp8_checker (.*);

// ----- sim/twelve_bit_minicomputer_core_tb.sv -----
// self-checking testbench for twelve_bit_minicomputer_core: streams commands and checks results
// against an instruction-level predictor kept in a scoreboard class
// depends on pdp8_pkg and the core rtl
module twelve_bit_minicomputer_core_tb
  import pdp8_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] acc;
    logic              lnk;
    logic [WORD_W-1:0] word;
    logic              halt;
    logic              iot;
  } core_result_t;

  class core_scoreboard;
    logic [WORD_W-1:0] mem [MEMORY_WORDS];
    bit                written [MEMORY_WORDS];
    logic [WORD_W-1:0] pc, acc, mdr, switch_word;
    logic              lnk, halted;
    core_result_t      pending_results [$];
    int                errors, checked;

    function new();
      pc = '0;
      acc = '0;
      mdr = '0;
      lnk = 1'b0;
      halted = 1'b1;
      switch_word = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void store(logic [WORD_W-1:0] a, logic [WORD_W-1:0] v);
      mem[mem_index(a)] = v;
      written[mem_index(a)] = 1'b1;
    endfunction

    function logic [WORD_W-1:0] peek(logic [WORD_W-1:0] a);
      return mem[mem_index(a)];
    endfunction

    function bit known(logic [WORD_W-1:0] a);
      return written[mem_index(a)];
    endfunction

    function logic [WORD_W-1:0] operand_addr(logic [WORD_W-1:0] here, logic [WORD_W-1:0] w);
      return w[7] ? {here[11:7], w[6:0]} : {5'b0, w[6:0]};
    endfunction

    function bit is_autoinc(logic [WORD_W-1:0] a);
      return a >= AUTOINC_BASE && a <= AUTOINC_BASE + 12'd7;
    endfunction

    // first never-written word the next step would read, or -1
    function int unwritten_read();
      logic [WORD_W-1:0] w, ea, ptr;
      opcode_e op;
      if (halted) return -1;
      if (!known(pc)) return pc;
      w = peek(pc);
      op = opcode_e'(w[11:9]);
      if (op == OP_IOT || op == OP_OPR) return -1;
      ea = operand_addr(pc, w);
      if (w[8]) begin
        if (!known(ea)) return ea;
        ptr = peek(ea);
        if (is_autoinc(ea)) ptr = ptr + 12'd1;
        ea = ptr;
      end
      if ((op == OP_AND || op == OP_TAD || op == OP_ISZ) && !known(ea)) return ea;
      return -1;
    endfunction

    function void operate_group1(logic [WORD_W-1:0] w);
      logic [WORD_W:0] sum;
      if (w[7]) acc = '0;
      if (w[6]) lnk = 1'b0;
      if (w[5]) acc = ~acc;
      if (w[4]) lnk = ~lnk;
      if (w[0]) begin
        sum = {1'b0, acc} + 13'd1;
        if (sum[WORD_W]) lnk = ~lnk;
        acc = sum[WORD_W-1:0];
      end
      if (w[3]) repeat (w[1] ? 2 : 1) {lnk, acc} = {acc[0], lnk, acc[11:1]};
      if (w[2]) repeat (w[1] ? 2 : 1) {lnk, acc} = {acc[11], acc[10:0], lnk};
    endfunction

    function void operate_group2(logic [WORD_W-1:0] w);
      bit cond, skip;
      cond = (w[6] && acc[11]) || (w[5] && acc == '0) || (w[4] && lnk);
      skip = w[3] ? !cond : cond;
      if (skip) pc = pc + 12'd1;
      if (w[7]) acc = '0;
      if (w[2]) acc = acc | switch_word;
      if (w[1]) halted = 1'b1;
    endfunction

    function void execute_instruction(output bit iot);
      logic [WORD_W-1:0] here, w, ea, ptr;
      logic [WORD_W:0] sum;
      opcode_e op;
      iot = 1'b0;
      here = pc;
      w = peek(here);
      op = opcode_e'(w[11:9]);
      ea = operand_addr(here, w);
      mdr = w;
      pc = here + 12'd1;
      if (op == OP_IOT) begin
        iot = 1'b1;
        return;
      end
      if (op == OP_OPR) begin
        if (!w[8]) operate_group1(w);
        else if (!w[0]) operate_group2(w);
        else if (w[7]) acc = '0;
        return;
      end
      if (w[8]) begin
        ptr = peek(ea);
        if (is_autoinc(ea)) begin
          ptr = ptr + 12'd1;
          store(ea, ptr);
        end
        mdr = ptr;
        ea = ptr;
      end
      case (op)
        OP_AND: begin
          mdr = peek(ea);
          acc = acc & mdr;
        end
        OP_TAD: begin
          mdr = peek(ea);
          sum = {1'b0, acc} + {1'b0, mdr};
          if (sum[WORD_W]) lnk = ~lnk;
          acc = sum[WORD_W-1:0];
        end
        OP_ISZ: begin
          mdr = peek(ea) + 12'd1;
          store(ea, mdr);
          if (mdr == '0) pc = pc + 12'd1;
        end
        OP_DCA: begin
          mdr = acc;
          store(ea, acc);
          acc = '0;
        end
        OP_JMS: begin
          mdr = pc;
          store(ea, pc);
          pc = ea + 12'd1;
        end
        default: pc = ea;
      endcase
    endfunction

    function void note_command(cmd_e cmd, logic [WORD_W-1:0] addr, logic [WORD_W-1:0] data);
      core_result_t r;
      bit iot;
      iot = 1'b0;
      case (cmd)
        CMD_STEP: if (!halted) execute_instruction(iot);
        CMD_DEPOSIT: begin
          store(addr, data);
          mdr = data;
        end
        CMD_LOAD_PC: pc = addr;
        default: begin
          acc = '0;
          lnk = 1'b0;
          mdr = '0;
          halted = 1'b0;
        end
      endcase
      r.pc = pc;
      r.acc = acc;
      r.lnk = lnk;
      r.word = mdr;
      r.halt = halted;
      r.iot = iot;
      pending_results.push_back(r);
    endfunction

    function void compare(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
      if (act !== exp) begin
        $error("%s: expected %0o, actual %0o", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] t);
      core_result_t e;
      checked++;
      if (pending_results.size() == 0) begin
        $error("result with no item pending: %0h", t);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      compare("program_counter_out", e.pc, t[11:0]);
      compare("accumulator_out", e.acc, t[23:12]);
      compare("link_out", 12'(e.lnk), 12'(t[24]));
      compare("last_word", e.word, t[36:25]);
      compare("halted_out", 12'(e.halt), 12'(t[37]));
      compare("unsupported", 12'(e.iot), 12'(t[38]));
      compare("zero", 12'd0, 12'(t[39]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [WORD_W-1:0]     cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  core_scoreboard sb;
  bit             idle_on = 1'b1;
  bit             hold_pending = 1'b1;
  int             counted = 0;
  int             stall_cycles = 0;

  twelve_bit_minicomputer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WORD_W-1:0] rand_instr();
    logic [WORD_W-1:0] w;
    w = 12'($urandom);
    // indirect through the auto-increment pointers
    if (w[11:9] < OP_IOT && $urandom_range(0, 3) == 0)
      w[8:0] = {1'b1, 1'b0, 4'b0001, 3'($urandom)};
    return w;
  endfunction

  task automatic send_item(cmd_e cmd, logic [WORD_W-1:0] addr, logic [WORD_W-1:0] data);
    int n;
    n = gap_len();
    @(negedge clk_i);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {data, addr};
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (!(cmd == CMD_STEP && sb.halted)) counted++;
    sb.note_command(cmd, addr, data);
  endtask

  // fills any never-written word the step would read, then steps
  task automatic do_step();
    int a;
    a = sb.unwritten_read();
    while (a >= 0) begin
      send_item(CMD_DEPOSIT, 12'(a), (12'(a) == sb.pc) ? rand_instr() : 12'($urandom));
      a = sb.unwritten_read();
    end
    send_item(CMD_STEP, 12'($urandom), 12'($urandom));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_switch(logic [WORD_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.switch_word = v;
  endtask

  task automatic run_directed();
    logic [WORD_W-1:0] prog [logic [WORD_W-1:0]];
    prog[12'o0200] = 12'o7301;  // cla cll iac
    prog[12'o0201] = 12'o1250;  // tad, carry out
    prog[12'o0202] = 12'o7560;  // sma sza snl
    prog[12'o0204] = 12'o2251;  // isz to zero
    prog[12'o0206] = 12'o3252;  // dca
    prog[12'o0207] = 12'o4253;  // jms
    prog[12'o0254] = 12'o5410;  // jmp indirect, auto-increment
    prog[12'o0300] = 12'o6001;  // iot
    prog[12'o0301] = 12'o7601;  // group 3 cla
    prog[12'o0302] = 12'o7604;  // cla osr
    prog[12'o0303] = 12'o7076;  // cma cml rtr rtl
    prog[12'o0304] = 12'o0420;  // and indirect
    prog[12'o0305] = 12'o7410;  // skp
    prog[12'o0307] = 12'o7402;  // hlt
    prog[12'o0250] = 12'o7777;
    prog[12'o0251] = 12'o7777;
    prog[12'o0010] = 12'o0277;
    prog[12'o0020] = 12'o7777;
    prog[12'o7777] = 12'o7777;
    prog[12'o0000] = 12'o0000;
    send_item(CMD_STEP, 12'o7777, 12'o7777);
    foreach (prog[a]) send_item(CMD_DEPOSIT, a, prog[a]);
    send_item(CMD_LOAD_PC, 12'o0200, 12'o0000);
    send_item(CMD_START, 12'o0000, 12'o7777);
    repeat (15) do_step();
    send_item(CMD_LOAD_PC, 12'o7777, 12'o0000);
    send_item(CMD_START, 12'o7777, 12'o0000);
    repeat (2) do_step();
  endtask

  task automatic random_phase(int target);
    int r;
    logic [WORD_W-1:0] a;
    target = counted + target;
    while (counted < target) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0: a = 12'($urandom);
        1: a = sb.pc + 12'($urandom_range(0, 7));
        default: a = $urandom_range(0, 1) ? 12'o7777 : 12'o0000;
      endcase
      if (sb.halted) begin
        if (r < 55) send_item(CMD_START, 12'($urandom), 12'($urandom));
        else if (r < 70) send_item(CMD_STEP, 12'($urandom), 12'($urandom));
        else if (r < 85) send_item(CMD_LOAD_PC, a, 12'($urandom));
        else send_item(CMD_DEPOSIT, a, rand_instr());
      end else begin
        if (r < 82) do_step();
        else if (r < 90) send_item(CMD_DEPOSIT, a, r[0] ? rand_instr() : 12'($urandom));
        else if (r < 96) send_item(CMD_LOAD_PC, a, 12'($urandom));
        else send_item(CMD_START, 12'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = gap_len();
      if (hold_pending && sb.checked >= 600) begin
        hold_pending = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** twelve_bit_minicomputer_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [WORD_W-1:0] switch_values [5];
    sb = new();
    switch_values = '{12'o0000, 12'o7777, 12'($urandom), 12'o5252, 12'($urandom)};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_switch(12'o7777);
    run_directed();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      idle_on = (ph != 1);
      write_switch(switch_values[ph]);
      random_phase(250);
      drain();
    end
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("** twelve_bit_minicomputer_core: PASSED **");
    end else begin
      $display("** twelve_bit_minicomputer_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- twelve_bit_minicomputer_core.f -----
+incdir+rtl
rtl/pdp8_pkg.sv
rtl/pdp8_ram.sv
rtl/twelve_bit_minicomputer_core.sv
rtl/pdp8_checker.sv
sim/twelve_bit_minicomputer_core_tb.sv
